/* rtl/core/kpdt_pkg.sv */
// Package for the keypad-set decimal countdown timer core.
// Holds command codes, mode codes, digit constants and the cell control structs.
// No dependencies.
`default_nettype none

package kpdt_pkg;

   // Number of BCD digits in the remaining count: four seconds, two centiseconds
   localparam int unsigned REM_DIGITS = 6;
   localparam int unsigned REM_W      = 4 * REM_DIGITS;
   localparam int unsigned CENTI_DIGITS = 2;

   // Largest decimal digit value
   localparam logic [3:0] DIGIT_MAX = 4'd9;

   // Widths of the result fields
   localparam int unsigned ENTRY_BCD_W = 16;
   localparam int unsigned ENTRY_CNT_W = 3;

   typedef enum logic [2:0] {
      CMD_DIGIT  = 3'd0,
      CMD_ERASE  = 3'd1,
      CMD_START  = 3'd2,
      CMD_TICK   = 3'd3,
      CMD_PAUSE  = 3'd4,
      CMD_RESUME = 3'd5,
      CMD_RESET  = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_ENTRY = 2'd0,
      MODE_RUN   = 2'd1,
      MODE_PAUSE = 2'd2,
      MODE_DONE  = 2'd3
   } mode_type;

   // Control shared by all entry digit cells
   typedef struct packed {
      logic shift_up;    // take the lower neighbor's digit
      logic shift_down;  // take the upper neighbor's digit
      logic clear;
   } ent_ctl_type;

   // Control shared by all remaining-count digit cells
   typedef struct packed {
      logic load;
      logic clear;
   } rem_ctl_type;

endpackage : kpdt_pkg

`default_nettype wire

/* rtl/core/kpdt_if.sv */
// Handshake channels of the countdown timer core: request and response item.
// Depends on kpdt_pkg for field widths.
`default_nettype none

interface kpdt_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] command;
   logic [3:0] digit;

   modport source (output valid, output command, output digit, input ready);
   modport sink   (input valid, input command, input digit, output ready);
endinterface : kpdt_req_if

interface kpdt_rsp_if;
   import kpdt_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [1:0]             mode;
   logic [ENTRY_BCD_W-1:0] entry_bcd;
   logic [ENTRY_CNT_W-1:0] entered_count;
   logic [REM_W-1:0]       remaining_bcd;
   logic                   time_up;

   modport source (output valid, output mode, output entry_bcd, output entered_count,
                   output remaining_bcd, output time_up, input ready);
   modport sink   (input valid, input mode, input entry_bcd, input entered_count,
                   input remaining_bcd, input time_up, output ready);
endinterface : kpdt_rsp_if

`default_nettype wire

/* rtl/core/keypad_set_decimal_countdown_timer_core.sv */
// Keypad-set decimal countdown timer core.
// Each accepted request item yields a response item, held in the response register from the cycle after.
// One item per cycle while the response side is ready; the response register refills in the cycle it drains.
// The borrow ripple through the six count cells sets the longest path.
// Synchronous reset: entry mode, empty entry, zero count, no response pending.
// Depends on kpdt_pkg, kpdt_if, kpdt_entry_cell and kpdt_count_cell.
`default_nettype none

module keypad_set_decimal_countdown_timer_core
   import kpdt_pkg::*;
#(
   parameter int unsigned ENTRY_DIGITS = 4
)(
   input  wire logic   clock,
   input  wire logic   reset,
   kpdt_req_if.sink    req_ch,
   kpdt_rsp_if.source  rsp_ch
);

   localparam int unsigned ENT_W = 4 * ENTRY_DIGITS;
   localparam int unsigned CNT_W = $clog2(ENTRY_DIGITS + 1);

   logic accept;

   mode_type         mode_ff, mode_in;
   logic [CNT_W-1:0] count_ff, count_in;
   ent_ctl_type      ent_ctl;
   rem_ctl_type      rem_ctl;
   logic             dec_en;
   logic             time_up_c;

   logic [ENT_W-1:0] ent_q, ent_d;
   logic [REM_W-1:0] rem_q, rem_d;
   logic [REM_DIGITS:0] borrow;

   logic                   rsp_valid_ff;
   logic [1:0]             rsp_mode_ff;
   logic [ENTRY_BCD_W-1:0] rsp_entry_ff;
   logic [ENTRY_CNT_W-1:0] rsp_count_ff;
   logic [REM_W-1:0]       rsp_remain_ff;
   logic                   rsp_time_up_ff;

   logic [31:0] ent_wide;
   logic [7:0]  cnt_wide;

   cmd_type cmd;

   assign cmd           = cmd_type'(req_ch.command);
   assign req_ch.ready  = !rsp_valid_ff || rsp_ch.ready;
   assign accept        = req_ch.valid && req_ch.ready;

   // Entry digit chain, lowest digit first
   for (genvar k = 0; k < ENTRY_DIGITS; k++) begin : g_ent
      logic [3:0] lower;
      logic [3:0] upper;
      if (k == 0) begin : g_low
         assign lower = req_ch.digit;
      end else begin : g_mid
         assign lower = ent_q[4*(k-1) +: 4];
      end
      if (k == ENTRY_DIGITS - 1) begin : g_top
         assign upper = 4'd0;
      end else begin : g_below
         assign upper = ent_q[4*(k+1) +: 4];
      end
      kpdt_entry_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ent_ctl),
         .from_lower (lower),
         .from_upper (upper),
         .digit_q    (ent_q[4*k +: 4]),
         .digit_d    (ent_d[4*k +: 4])
      );
   end

   // Remaining-time counter chain; borrow ripples upward from the lowest centisecond
   assign borrow[0] = dec_en;
   for (genvar i = 0; i < REM_DIGITS; i++) begin : g_rem
      logic [3:0] load_val;
      if (i >= CENTI_DIGITS && i - CENTI_DIGITS < ENTRY_DIGITS) begin : g_src
         assign load_val = ent_q[4*(i-CENTI_DIGITS) +: 4];
      end else begin : g_zero
         assign load_val = 4'd0;
      end
      kpdt_count_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (rem_ctl),
         .load_digit (load_val),
         .borrow_in  (borrow[i]),
         .borrow_out (borrow[i+1]),
         .digit_q    (rem_q[4*i +: 4]),
         .digit_d    (rem_d[4*i +: 4])
      );
   end

   // Decode the accepted item into mode, count and cell controls
   always_comb begin
      mode_in   = mode_ff;
      count_in  = count_ff;
      ent_ctl   = '0;
      rem_ctl   = '0;
      dec_en    = 1'b0;
      time_up_c = 1'b0;
      if (accept) begin
         case (cmd)
            CMD_DIGIT: begin
               if (mode_ff == MODE_ENTRY && count_ff < CNT_W'(ENTRY_DIGITS)
                   && req_ch.digit <= DIGIT_MAX) begin
                  ent_ctl.shift_up = 1'b1;
                  count_in         = count_ff + CNT_W'(1);
               end
            end
            CMD_ERASE: begin
               if (mode_ff == MODE_ENTRY && count_ff != '0) begin
                  ent_ctl.shift_down = 1'b1;
                  count_in           = count_ff - CNT_W'(1);
               end
            end
            CMD_START: begin
               if (mode_ff == MODE_ENTRY && count_ff != '0) begin
                  rem_ctl.load = 1'b1;
                  if (rem_d == '0) begin
                     mode_in   = MODE_DONE;
                     time_up_c = 1'b1;
                  end else begin
                     mode_in = MODE_RUN;
                  end
               end
            end
            CMD_TICK: begin
               if (mode_ff == MODE_RUN) begin
                  dec_en = (rem_q != '0);
                  if (rem_d == '0) begin
                     mode_in   = MODE_DONE;
                     time_up_c = 1'b1;
                  end
               end
            end
            CMD_PAUSE: begin
               if (mode_ff == MODE_RUN) begin
                  mode_in = MODE_PAUSE;
               end
            end
            CMD_RESUME: begin
               if (mode_ff == MODE_PAUSE) begin
                  mode_in = MODE_RUN;
               end
            end
            CMD_RESET: begin
               mode_in       = MODE_ENTRY;
               count_in      = '0;
               ent_ctl.clear = 1'b1;
               rem_ctl.clear = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // Hold mode and digit count
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_ENTRY;
         count_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
   end

   // Fit the entry and count into the result field widths
   assign ent_wide = 32'(ent_d);
   assign cnt_wide = 8'(count_in);

   // Response register: valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response register: capture the updated state of each accepted item
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_mode_ff    <= mode_in;
         rsp_entry_ff   <= ent_wide[ENTRY_BCD_W-1:0];
         rsp_count_ff   <= cnt_wide[ENTRY_CNT_W-1:0];
         rsp_remain_ff  <= rem_d;
         rsp_time_up_ff <= time_up_c;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.mode          = rsp_mode_ff;
   assign rsp_ch.entry_bcd     = rsp_entry_ff;
   assign rsp_ch.entered_count = rsp_count_ff;
   assign rsp_ch.remaining_bcd = rsp_remain_ff;
   assign rsp_ch.time_up       = rsp_time_up_ff;

endmodule : keypad_set_decimal_countdown_timer_core

`default_nettype wire

/* rtl/core/kpdt_entry_cell.sv */
// One digit cell of the keypad entry shift chain.
// Depends on kpdt_pkg for the control struct.
`default_nettype none

module kpdt_entry_cell
   import kpdt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire ent_ctl_type ctl,
   input  wire logic [3:0]  from_lower,
   input  wire logic [3:0]  from_upper,
   output logic [3:0]       digit_q,
   output logic [3:0]       digit_d
);

   logic [3:0] digit_ff;
   logic [3:0] digit_in;

   // Pick the next digit: clear, shift toward the top, or shift toward the bottom
   always_comb begin
      digit_in = digit_ff;
      if (ctl.clear) begin
         digit_in = '0;
      end else if (ctl.shift_up) begin
         digit_in = from_lower;
      end else if (ctl.shift_down) begin
         digit_in = from_upper;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff <= '0;
      end else begin
         digit_ff <= digit_in;
      end
   end

   assign digit_q = digit_ff;
   assign digit_d = digit_in;

endmodule : kpdt_entry_cell

`default_nettype wire

/* rtl/core/kpdt_count_cell.sv */
// One BCD digit cell of the remaining-time down counter, with decimal borrow.
// Depends on kpdt_pkg for the control struct and digit constant.
`default_nettype none

module kpdt_count_cell
   import kpdt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire rem_ctl_type ctl,
   input  wire logic [3:0]  load_digit,
   input  wire logic        borrow_in,
   output logic             borrow_out,
   output logic [3:0]       digit_q,
   output logic [3:0]       digit_d
);

   logic [3:0] digit_ff;
   logic [3:0] digit_in;
   logic       is_zero;

   assign is_zero    = (digit_ff == 4'd0);
   // Pass the borrow on when this digit wraps from zero to nine
   assign borrow_out = borrow_in && is_zero;

   always_comb begin
      digit_in = digit_ff;
      if (ctl.clear) begin
         digit_in = '0;
      end else if (ctl.load) begin
         digit_in = load_digit;
      end else if (borrow_in) begin
         digit_in = is_zero ? DIGIT_MAX : digit_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff <= '0;
      end else begin
         digit_ff <= digit_in;
      end
   end

   assign digit_q = digit_ff;
   assign digit_d = digit_in;

endmodule : kpdt_count_cell

`default_nettype wire

/* bench/keypad_set_decimal_countdown_timer_core_tb.sv */
// Testbench for the keypad-set decimal countdown timer core.
// Drives key, switch and tick items, predicts each status item and checks it field by field.
// Depends on kpdt_pkg, kpdt_if and the core itself.
`timescale 1ns / 1ps

module keypad_set_decimal_countdown_timer_core_tb;
   import kpdt_pkg::*;

   localparam int unsigned ENTRY_SLOTS = 4;
   localparam int unsigned ITEM_TARGET = 1450;
   localparam int unsigned IDLE_PCT    = 21;
   // Command code that no key or switch produces
   localparam logic [2:0]  CMD_UNUSED  = 3'd7;

   typedef struct {
      mode_type    mode;
      logic [15:0] entry;
      logic [2:0]  count;
      logic [23:0] remaining;
      logic        time_up;
   } timer_status_type;

   // Tracks the timer state and holds the status items still due
   class timer_status_tracker;
      mode_type         mode;
      logic [15:0]      entry;
      logic [2:0]       count;
      logic [23:0]      remaining;
      timer_status_type status_due[$];
      int unsigned      errors;

      function new();
         mode      = MODE_ENTRY;
         entry     = '0;
         count     = '0;
         remaining = '0;
         errors    = 0;
      endfunction

      // Subtract one centisecond with decimal borrow
      function logic [23:0] bcd_minus_one(logic [23:0] v);
         logic [23:0] r;
         logic        borrow;
         r      = v;
         borrow = 1'b1;
         for (int i = 0; i < REM_DIGITS; i++) begin
            if (borrow) begin
               if (r[4*i +: 4] == 4'd0) begin
                  r[4*i +: 4] = DIGIT_MAX;
               end else begin
                  r[4*i +: 4] = r[4*i +: 4] - 4'd1;
                  borrow      = 1'b0;
               end
            end
         end
         return r;
      endfunction

      // Advance the state for one accepted item and queue the status it yields
      function void apply_command(logic [2:0] cmd, logic [3:0] dig);
         timer_status_type s;
         s.time_up = 1'b0;
         case (cmd)
            CMD_DIGIT: begin
               if (mode == MODE_ENTRY && count < ENTRY_SLOTS && dig <= DIGIT_MAX) begin
                  entry = {entry[11:0], dig};
                  count = count + 3'd1;
               end
            end
            CMD_ERASE: begin
               if (mode == MODE_ENTRY && count != 0) begin
                  entry = entry >> 4;
                  count = count - 3'd1;
               end
            end
            CMD_START: begin
               if (mode == MODE_ENTRY && count != 0) begin
                  remaining = {entry, 8'h00};
                  if (remaining == 0) begin
                     mode      = MODE_DONE;
                     s.time_up = 1'b1;
                  end else begin
                     mode = MODE_RUN;
                  end
               end
            end
            CMD_TICK: begin
               if (mode == MODE_RUN) begin
                  if (remaining != 0) remaining = bcd_minus_one(remaining);
                  if (remaining == 0) begin
                     mode      = MODE_DONE;
                     s.time_up = 1'b1;
                  end
               end
            end
            CMD_PAUSE: begin
               if (mode == MODE_RUN) mode = MODE_PAUSE;
            end
            CMD_RESUME: begin
               if (mode == MODE_PAUSE) mode = MODE_RUN;
            end
            CMD_RESET: begin
               mode      = MODE_ENTRY;
               entry     = '0;
               count     = '0;
               remaining = '0;
            end
            default: begin
            end
         endcase
         s.mode      = mode;
         s.entry     = entry;
         s.count     = count;
         s.remaining = remaining;
         status_due.push_back(s);
      endfunction

      // Check one status item against the oldest one due
      function void compare_status(logic [1:0] m, logic [15:0] e, logic [2:0] c,
                                   logic [23:0] r, logic t);
         timer_status_type s;
         if (status_due.size() == 0) begin
            $error("status item with none due");
            errors++;
            return;
         end
         s = status_due.pop_front();
         if (m !== s.mode) begin
            $error("mode: expected %0d, got %0d", s.mode, m);
            errors++;
         end
         if (e !== s.entry) begin
            $error("entry_bcd: expected %h, got %h", s.entry, e);
            errors++;
         end
         if (c !== s.count) begin
            $error("entered_count: expected %0d, got %0d", s.count, c);
            errors++;
         end
         if (r !== s.remaining) begin
            $error("remaining_bcd: expected %h, got %h", s.remaining, r);
            errors++;
         end
         if (t !== s.time_up) begin
            $error("time_up: expected %0d, got %0d", s.time_up, t);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return status_due.size();
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                no_idle;
   int unsigned         items_sent;
   timer_status_tracker tracker;

   kpdt_req_if req_ch ();
   kpdt_rsp_if rsp_ch ();

   keypad_set_decimal_countdown_timer_core #(
      .ENTRY_DIGITS (ENTRY_SLOTS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Sample both handshakes at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            tracker.apply_command(req_ch.command, req_ch.digit);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            tracker.compare_status(rsp_ch.mode, rsp_ch.entry_bcd, rsp_ch.entered_count,
                                   rsp_ch.remaining_bcd, rsp_ch.time_up);
      end
   end

   // Status receiver: random stalls, plus long hold-offs so the core backs up
   initial begin
      int unsigned cycle_no;
      int unsigned hold_left;
      bit          long_done;
      cycle_no     = 0;
      hold_left    = 0;
      long_done    = 1'b0;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         cycle_no++;
         // keep the no-idle stretch free of hold-offs
         if (hold_left == 0 && !no_idle
             && ((cycle_no >= 300 && !long_done) || $urandom_range(0, 999) == 0)) begin
            hold_left = $urandom_range(40, 80);
            long_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (no_idle) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end
         @(negedge clock);
      end
   end

   // Offer one item from a falling edge and hold it until accepted
   task automatic send_item(input logic [2:0] cmd, input logic [3:0] dig);
      while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.command <= cmd;
      req_ch.digit   <= dig;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // One countdown from a cleared entry, or a burst of arbitrary items
   task automatic run_session();
      int unsigned kind;
      int unsigned n;
      int unsigned secs;
      int unsigned ticks;
      int unsigned r;
      logic [3:0]  d;
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
         repeat ($urandom_range(8, 25))
            send_item(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
         return;
      end
      send_item(CMD_RESET, 4'($urandom_range(0, 15)));
      n    = $urandom_range(1, ENTRY_SLOTS);
      secs = 0;
      for (int i = 0; i < n; i++) begin
         // short counts reach zero; a leading one over zeros borrows through many digits
         if (kind < 45)
            d = (i == n - 1) ? 4'($urandom_range(0, 1)) : 4'd0;
         else if (kind < 60)
            d = (i == 0) ? 4'd1 : 4'd0;
         else
            d = 4'($urandom_range(0, 9));
         send_item(CMD_DIGIT, d);
         secs = secs * 10 + d;
         if ($urandom_range(0, 99) < 15) begin
            send_item(CMD_ERASE, 4'($urandom_range(0, 15)));
            send_item(CMD_DIGIT, d);
         end
      end
      send_item(CMD_START, 4'($urandom_range(0, 15)));
      ticks = (secs <= 1) ? secs * 100 + $urandom_range(1, 3) : $urandom_range(1, 60);
      repeat (ticks) begin
         r = $urandom_range(0, 99);
         if (r < 4) begin
            send_item(CMD_PAUSE, 4'($urandom_range(0, 15)));
            repeat ($urandom_range(0, 3)) send_item(CMD_TICK, 4'($urandom_range(0, 15)));
            send_item(CMD_RESUME, 4'($urandom_range(0, 15)));
         end else if (r < 8) begin
            send_item(3'($urandom_range(CMD_DIGIT, CMD_START)), 4'($urandom_range(0, 15)));
         end
         send_item(CMD_TICK, 4'($urandom_range(0, 15)));
      end
   endtask

   // Reset, directed items, random sessions, drain
   initial begin
      int unsigned session_no;
      tracker        = new();
      reset          = 1'b1;
      no_idle        = 1'b0;
      items_sent     = 0;
      session_no     = 0;
      req_ch.valid   = 1'b0;
      req_ch.command = CMD_DIGIT;
      req_ch.digit   = 4'd0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // full entry, then a digit past it, erase, and a digit no key makes
      repeat (4) send_item(CMD_DIGIT, 4'd9);
      send_item(CMD_DIGIT, 4'd0);
      send_item(CMD_ERASE, 4'd0);
      send_item(CMD_ERASE, 4'd15);
      send_item(CMD_DIGIT, 4'd15);
      // run, pause with ignored keys, resume
      send_item(CMD_START, 4'd0);
      send_item(CMD_TICK, 4'd0);
      send_item(CMD_PAUSE, 4'd0);
      send_item(CMD_TICK, 4'd0);
      send_item(CMD_DIGIT, 4'd3);
      send_item(CMD_RESUME, 4'd0);
      send_item(CMD_TICK, 4'd0);
      send_item(CMD_UNUSED, 4'd0);
      // keys with an empty entry and outside their mode
      send_item(CMD_RESET, 4'd0);
      send_item(CMD_ERASE, 4'd0);
      send_item(CMD_START, 4'd0);
      send_item(CMD_TICK, 4'd0);
      send_item(CMD_PAUSE, 4'd0);
      send_item(CMD_RESUME, 4'd0);
      // all-zero entry finishes at once; done holds until reset
      send_item(CMD_DIGIT, 4'd0);
      send_item(CMD_START, 4'd0);
      send_item(CMD_TICK, 4'd0);
      send_item(CMD_RESET, 4'd0);

      while (items_sent < ITEM_TARGET) begin
         no_idle = (session_no >= 4 && session_no < 8);
         run_session();
         session_no++;
      end
      no_idle      = 1'b0;
      req_ch.valid <= 1'b0;

      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("keypad_set_decimal_countdown_timer_core: match");
      end else begin
         $display("keypad_set_decimal_countdown_timer_core: mismatch");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("keypad_set_decimal_countdown_timer_core: mismatch");
      $finish;
   end

endmodule : keypad_set_decimal_countdown_timer_core_tb
